// ----- hw/rtl/half_precision_converter_macros.svh -----
// Assertion helpers for the converter.
`ifndef HALF_PRECISION_CONVERTER_MACROS_SVH
`define HALF_PRECISION_CONVERTER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HPC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HPC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/hpc_pkg.sv -----
package hpc_pkg;
  typedef enum logic [1:0] {
    KIND_F32_F16 = 2'd0,
    KIND_F64_F16 = 2'd1,
    KIND_F16_F32 = 2'd2,
    KIND_F16_F64 = 2'd3
  } kind_t;

  localparam logic [15:0] HALF_INF = 16'h7C00;
endpackage

// ----- hw/rtl/half_precision_converter.sv -----
// Path: input register, then result register; conversion logic sits between them.
// Throughput: one transaction per cycle while out_stall does not hold the pipeline.
// A waiting result does not block input while the result register can be refilled.
// Reset (rst, synchronous, active high) clears both valid flags; payload is not reset.
module half_precision_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_out
);
`include "half_precision_converter_macros.svh"

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [63:0] s1_data;
  logic        s1_adv;
  logic        out_free;
  logic [31:0] nar_hi;
  logic [15:0] nar_half;
  logic [31:0] wid_word;
  logic [63:0] result;

  // Advance stage 1 into the output register when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_data <= data_in;
    end
  end

  // Kind 1 reads only the upper word of the double.
  assign nar_hi = (s1_kind == hpc_pkg::KIND_F64_F16) ? s1_data[63:32] : s1_data[31:0];

  hpc_narrow u_narrow (
    .hi   (nar_hi),
    .wide (s1_kind == hpc_pkg::KIND_F64_F16),
    .half (nar_half)
  );

  hpc_widen u_widen (
    .h    (s1_data[15:0]),
    .wide (s1_kind == hpc_pkg::KIND_F16_F64),
    .word (wid_word)
  );

  always_comb begin
    case (s1_kind)
      hpc_pkg::KIND_F32_F16,
      hpc_pkg::KIND_F64_F16: result = {48'd0, nar_half};
      hpc_pkg::KIND_F16_F32: result = {32'd0, wid_word};
      hpc_pkg::KIND_F16_F64: result = {wid_word, 32'd0};
      default:               result = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      data_out <= result;
    end
  end

  `HPC_ASSERT_IMPL(a_stall_only_full, in_stall, s1_valid && out_valid)
  `HPC_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid)
  `HPC_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(data_out))
endmodule

// ----- hw/rtl/hpc_narrow.sv -----
module hpc_narrow (
  input  logic [31:0] hi,
  input  logic        wide,
  output logic [15:0] half
);
  logic        sign;
  logic [10:0] e;
  logic [22:0] m;
  logic [10:0] emax;
  logic [12:0] he;
  logic [9:0]  top;
  logic        rbit;
  logic [23:0] mant;
  logic [4:0]  sh;
  logic [10:0] shifted;
  logic [11:0] r;
  logic [15:0] nrm;

  always_comb begin
    sign = hi[31];
    if (wide) begin
      e    = hi[30:20];
      m    = {hi[19:0], 3'b000};
      emax = 11'h7FF;
      he   = {2'b00, hi[30:20]} - 13'd1008;
    end else begin
      e    = {3'b000, hi[30:23]};
      m    = hi[22:0];
      emax = 11'h0FF;
      he   = {5'b00000, hi[30:23]} - 13'd112;
    end
    top  = m[22:13];
    rbit = m[12];
    mant = {1'b1, m};
    // shift by 13 - he for he in -10..0, computed from the low bits
    sh      = 5'(13'd13 - he);
    shifted = 11'(mant >> sh);
    r       = 12'(shifted >> 1) + {11'd0, shifted[0]};
    nrm     = {sign, he[4:0], top} + {15'd0, rbit};
    if (e == 11'd0) begin
      half = {sign, 15'd0};
    end else if (e == emax) begin
      if (m == 23'd0) half = {sign, 15'h7C00};
      else            half = {sign, 5'h1F, top | 10'd1};
    end else if (!he[12] && he >= 13'd31) begin
      half = {sign, hpc_pkg::HALF_INF[14:0]};
    end else if (he[12] || he == 13'd0) begin
      if ($signed(he) < -13'sd10) half = {sign, 15'd0};
      else                         half = {sign, 15'd0} | {4'd0, r};
    end else begin
      half = nrm;
    end
  end
endmodule

// ----- hw/rtl/hpc_widen.sv -----
module hpc_widen (
  input  logic [15:0] h,
  input  logic        wide,
  output logic [31:0] word
);
  logic [4:0]  e;
  logic [9:0]  m;
  logic [3:0]  lz;
  logic [9:0]  mn;
  logic [10:0] ew;
  logic [22:0] mw;

  always_comb begin
    e  = h[14:10];
    m  = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(10 - i);
    end
    mn = 10'(m << lz);
    ew = 11'd0;
    mw = 23'd0;
    if (h[14:0] == 15'd0) begin
      ew = 11'd0;
    end else if (e == 5'd0) begin
      ew = (wide ? 11'd1008 : 11'd112) - 11'(lz - 4'd1);
      mw = {mn, 13'd0};
    end else if (e == 5'd31) begin
      ew = wide ? 11'h7FF : 11'h0FF;
      mw = {m, 13'd0};
    end else begin
      ew = {6'd0, e} + (wide ? 11'd1008 : 11'd112);
      mw = {m, 13'd0};
    end
    if (wide) word = {h[15], ew, mw[22:3]};
    else      word = {h[15], ew[7:0], mw};
  end
endmodule
